// File: rtl/sorted_insert_priority_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Sorted insert priority queue assertion macros
// Clocked property checks, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check outside reset
`define SIPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every edge, reset included
`define SIPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SIPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SIPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/sipq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted insert priority queue package
// Sizes, operation and status codes, circular slot arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sipq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_UNUSED     = 2'd3
    } t_status;

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [VALUE_WIDTH-1:0] t_value;

    // (head + off) mod depth, with off no greater than the depth
    function automatic t_idx slot(input t_idx head, input t_cnt off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: rtl/sorted_insert_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Sorted insert priority queue
// Bounded descending-order queue of signed values in a circular RAM.
// ----------------------------------------------------------------------------
// One item at a time. A rejected enqueue (full), a rejected dequeue (empty) and
// an enqueue into an empty queue answer directly from the idle state, a dequeue
// reads the head entry and answers from S_DEQ, and any other enqueue walks past
// the stored entries smaller than the new value: the single RAM read port
// steps back from the tail, moving one entry per cycle until the insertion
// point is found. At most QUEUE_DEPTH - 1 entries are stored when an enqueue
// is taken.
// A finished result waits in the output register; the next item is taken as
// soon as that register is free or being emptied. No clearing pass is needed
// after reset, since only written entries are ever read.
`timescale 1ns / 1ps
`include "sorted_insert_priority_queue_top_assert.svh"

module sorted_insert_priority_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value_in[31:0]
    input  logic        s_axis_tuser,   // mode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // value_out[31:0], item_count[36:32], is_empty[37], is_full[38], zero[39]
    output logic [39:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_PUT,
        S_DEQ
    } t_state;

    localparam sipq_pkg::t_cnt FULL_CNT = sipq_pkg::CNT_W'(sipq_pkg::QUEUE_DEPTH);
    localparam sipq_pkg::t_cnt ONE_CNT  = sipq_pkg::CNT_W'(1);
    localparam sipq_pkg::t_cnt TWO_CNT  = sipq_pkg::CNT_W'(2);

    sipq_pkg::t_value r_mem [sipq_pkg::QUEUE_DEPTH];
    sipq_pkg::t_value r_rdata;

    t_state            r_state,      n_state;
    sipq_pkg::t_idx    r_head,       n_head;
    sipq_pkg::t_cnt    r_count,      n_count;
    sipq_pkg::t_cnt    r_k,          n_k;
    sipq_pkg::t_value  r_val,        n_val;
    logic              r_out_valid,  n_out_valid;
    sipq_pkg::t_value  r_out_value,  n_out_value;
    sipq_pkg::t_status r_out_status, n_out_status;
    sipq_pkg::t_cnt    r_out_count,  n_out_count;

    logic              rd_en;
    sipq_pkg::t_idx    rd_addr;
    logic              wr_en;
    sipq_pkg::t_idx    wr_addr;
    sipq_pkg::t_value  wr_data;
    logic              in_acc;
    logic              entry_less;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign entry_less    = $signed(r_rdata) < $signed(r_val);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_k          = r_k;
        n_val        = r_val;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        rd_en        = 1'b0;
        rd_addr      = r_head;
        wr_en        = 1'b0;
        wr_addr      = r_head;
        wr_data      = r_val;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_val = s_axis_tdata;
                    if (s_axis_tuser == sipq_pkg::OP_ENQUEUE) begin
                        if (r_count == FULL_CNT) begin
                            n_out_valid  = 1'b1;
                            n_out_value  = '0;
                            n_out_status = sipq_pkg::ST_FULL;
                            n_out_count  = r_count;
                        end else if (r_count == '0) begin
                            wr_en        = 1'b1;
                            wr_addr      = r_head;
                            wr_data      = s_axis_tdata;
                            n_count      = ONE_CNT;
                            n_out_valid  = 1'b1;
                            n_out_value  = '0;
                            n_out_status = sipq_pkg::ST_DONE;
                            n_out_count  = ONE_CNT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = sipq_pkg::slot(r_head, r_count - ONE_CNT);
                            n_k     = r_count;
                            n_state = S_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_value  = '0;
                            n_out_status = sipq_pkg::ST_EMPTY;
                            n_out_count  = r_count;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_state = S_DEQ;
                        end
                    end
                end
            end
            S_CMP: begin
                wr_en   = 1'b1;
                wr_addr = sipq_pkg::slot(r_head, r_k);
                if (entry_less) begin
                    // move the entry back one place and look further forward
                    wr_data = r_rdata;
                    n_k     = r_k - ONE_CNT;
                    if (r_k == ONE_CNT) begin
                        n_state = S_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = sipq_pkg::slot(r_head, r_k - TWO_CNT);
                    end
                end else begin
                    wr_data      = r_val;
                    n_count      = r_count + ONE_CNT;
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_status = sipq_pkg::ST_DONE;
                    n_out_count  = r_count + ONE_CNT;
                    n_state      = S_IDLE;
                end
            end
            S_PUT: begin
                wr_en        = 1'b1;
                wr_addr      = r_head;
                wr_data      = r_val;
                n_count      = r_count + ONE_CNT;
                n_out_valid  = 1'b1;
                n_out_value  = '0;
                n_out_status = sipq_pkg::ST_DONE;
                n_out_count  = r_count + ONE_CNT;
                n_state      = S_IDLE;
            end
            S_DEQ: begin
                n_count      = r_count - ONE_CNT;
                n_head       = (r_count == ONE_CNT) ? '0 : sipq_pkg::slot(r_head, ONE_CNT);
                n_out_valid  = 1'b1;
                n_out_value  = r_rdata;
                n_out_status = sipq_pkg::ST_DONE;
                n_out_count  = r_count - ONE_CNT;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_k          <= n_k;
        r_val        <= n_val;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0,
                            (r_out_count == FULL_CNT),
                            (r_out_count == '0),
                            5'(r_out_count),
                            32'(r_out_value)};

    `SIPQ_ASSERT(a_empty_head_zero, i_clk, i_rst_n, (r_count == '0) |-> (r_head == '0), "head not rewound on empty queue")
    `SIPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "entry count above depth")
    `SIPQ_ASSERT(a_reject_keeps, i_clk, i_rst_n, (in_acc && (s_axis_tuser == sipq_pkg::OP_DEQUEUE) && (r_count == '0)) |=> ((r_count == '0) && (r_state == S_IDLE)), "rejected dequeue changed state")
    `SIPQ_ASSERT_ALWAYS(a_busy_no_accept, i_clk, (r_state != S_IDLE) |-> !s_axis_tready, "item taken while busy")

endmodule

// File: bench/sorted_queue_checker.sv
// ----------------------------------------------------------------------------
// Sorted queue checker
// Watches both item channels of the priority queue. It keeps its own sorted
// copy of the store, works out the result of every accepted item and
// compares each returned item against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_queue_checker
    import sipq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,    // value_in[31:0]
    input  logic        i_s_tuser,    // mode[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // value_out[31:0], item_count[36:32], is_empty[37], is_full[38], zero[39]
    input  logic [39:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,    // status[1:0]
    output int          o_fail_count,
    output int          o_pending_count,
    output int          o_results_checked,
    output int          o_full_rejects,
    output int          o_empty_rejects
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_value  value;
        t_status status;
        t_cnt    count;
        logic    empty;
        logic    full;
        logic    pad;
    } t_queue_result;

    t_value        sorted_entries[$];
    t_queue_result pending_results[$];
    int            fail_total;
    int            checked_total;
    int            full_total;
    int            empty_total;

    // new value goes behind every entry >= it, so equal values keep arrival order
    function automatic t_queue_result apply_queue_op(input t_op op, input t_value val);
        t_queue_result r;
        int            pos;
        r        = '0;
        r.status = ST_DONE;
        if (op == OP_ENQUEUE) begin
            if (sorted_entries.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < sorted_entries.size() &&
                       !($signed(sorted_entries[pos]) < $signed(val))) begin
                    pos++;
                end
                sorted_entries.insert(pos, val);
            end
        end else if (sorted_entries.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.value = sorted_entries.pop_front();
        end
        r.count = t_cnt'(sorted_entries.size());
        r.empty = (sorted_entries.size() == 0);
        r.full  = (sorted_entries.size() == QUEUE_DEPTH);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_queue_result got;
        t_queue_result want;
        if (!i_rst_n) begin
            sorted_entries.delete();
            pending_results.delete();
            fail_total    = 0;
            checked_total = 0;
            full_total    = 0;
            empty_total   = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.value  = i_m_tdata[31:0];
                got.status = t_status'(i_m_tuser);
                got.count  = i_m_tdata[36:32];
                got.empty  = i_m_tdata[37];
                got.full   = i_m_tdata[38];
                got.pad    = i_m_tdata[39];
                checked_total++;
                if (pending_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT) begin
                        $display("[%0t] unexpected result item: value=%h status=%0d count=%0d",
                                 $realtime, got.value, got.status, got.count);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("[%0t] mismatch: exp value=%h st=%0d cnt=%0d e=%b f=%b pad=%b",
                                     $realtime, want.value, want.status, want.count,
                                     want.empty, want.full, want.pad);
                            $display("             got value=%h st=%0d cnt=%0d e=%b f=%b pad=%b",
                                     got.value, got.status, got.count,
                                     got.empty, got.full, got.pad);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = apply_queue_op(t_op'(i_s_tuser), i_s_tdata);
                if (want.status == ST_FULL)  full_total++;
                if (want.status == ST_EMPTY) empty_total++;
                pending_results.push_back(want);
            end
        end
        o_fail_count      <= fail_total;
        o_pending_count   <= pending_results.size();
        o_results_checked <= checked_total;
        o_full_rejects    <= full_total;
        o_empty_rejects   <= empty_total;
    end

endmodule

// File: bench/sorted_insert_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// Sorted insert priority queue testbench
// Drives enqueue and dequeue items with random gaps and output stalls: a
// short directed run over the value extremes and equal values, then random
// fill, drain and mixed phases that push the queue to full and empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_insert_priority_queue_top_tb;

    import sipq_pkg::*;

    localparam int ITEM_TARGET  = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = QUEUE_DEPTH + 4;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int   fail_count;
    int   pending_count;
    int   results_checked;
    int   full_rejects;
    int   empty_rejects;
    int   items_sent  = 0;
    int   cycle_count = 0;
    logic calm        = 1'b0;

    always #1 i_clk = ~i_clk;

    sorted_insert_priority_queue_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sorted_queue_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (s_axis_tvalid),
        .i_s_tready        (s_axis_tready),
        .i_s_tdata         (s_axis_tdata),
        .i_s_tuser         (s_axis_tuser),
        .i_m_tvalid        (m_axis_tvalid),
        .i_m_tready        (m_axis_tready),
        .i_m_tdata         (m_axis_tdata),
        .i_m_tuser         (m_axis_tuser),
        .o_fail_count      (fail_count),
        .o_pending_count   (pending_count),
        .o_results_checked (results_checked),
        .o_full_rejects    (full_rejects),
        .o_empty_rejects   (empty_rejects)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input t_op op, input t_value val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        for (int k = 0; k < gap; k++) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= val;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_value pick_value();
        case ($urandom_range(0, 3))
            0: return t_value'(int'($urandom_range(0, 8)) - 4);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            2: return t_value'(int'($urandom_range(0, 2000)) - 1000);
            default: return t_value'($urandom);
        endcase
    endfunction

    // output side: random stall before taking each result item
    initial begin : sink
        int stall;
        @(negedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            for (int k = 0; k < stall; k++) begin
                m_axis_tready <= 1'b0;
                @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int   kind;
        int   phase_len;
        t_op  op;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty reject, extremes, equal values, drain back to empty
        send_item(OP_DEQUEUE, 32'hFFFF_FFFF);
        send_item(OP_ENQUEUE, 32'h0000_0000);
        send_item(OP_ENQUEUE, 32'h7FFF_FFFF);
        send_item(OP_ENQUEUE, 32'h8000_0000);
        send_item(OP_ENQUEUE, 32'hFFFF_FFFF);
        send_item(OP_ENQUEUE, 32'h0000_0001);
        send_item(OP_ENQUEUE, 32'h0000_0000);
        send_item(OP_ENQUEUE, 32'h7FFF_FFFF);
        repeat (8) send_item(OP_DEQUEUE, 32'h0000_0000);
        send_item(OP_ENQUEUE, 32'h8000_0000);
        send_item(OP_ENQUEUE, 32'h8000_0000);
        send_item(OP_DEQUEUE, 32'h5555_AAAA);
        send_item(OP_DEQUEUE, 32'hAAAA_5555);

        // fill-heavy, drain-heavy and mixed phases
        while (items_sent < ITEM_TARGET) begin
            kind      = $urandom_range(0, 3);
            calm      = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(12, 24);
            repeat (phase_len) begin
                case (kind)
                    0: op = ($urandom_range(0, 9) < 9) ? OP_ENQUEUE : OP_DEQUEUE;
                    1: op = ($urandom_range(0, 9) < 1) ? OP_ENQUEUE : OP_DEQUEUE;
                    default: op = t_op'($urandom_range(0, 1));
                endcase
                send_item(op, (op == OP_ENQUEUE) ? pick_value() : t_value'($urandom));
            end
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        $display("Sent %0d items and checked %0d result items.", items_sent, results_checked);
        $display("Enqueues refused on a full queue: %0d, dequeues refused on an empty one: %0d.",
                 full_rejects, empty_rejects);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/sipq_pkg.sv
rtl/sorted_insert_priority_queue_top.sv
bench/sorted_queue_checker.sv
bench/sorted_insert_priority_queue_top_tb.sv
